FILE: sv/survey_join_distance_bearing_defines.svh
// Assertion macros for the survey join block.
// Used by the top level; depends on a clock named clk_i and a reset named rst_ni.
`ifndef SURVEY_JOIN_DISTANCE_BEARING_DEFINES_SVH
`define SURVEY_JOIN_DISTANCE_BEARING_DEFINES_SVH
`ifndef ASSERT_OFF
`define SJDB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SJDB_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SJDB_ASSERT(lbl, prop, msg)
`define SJDB_ASSERT_NR(lbl, prop, msg)
`endif
`endif

FILE: sv/sjdb_pkg.sv
// Shared types, constants and elaboration-time functions for the survey join block.
// No dependencies.
`timescale 1ns / 1ps
package sjdb_pkg;

  localparam int unsigned SQRT_STEPS = 32;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [63:0] PI_OVER_4_Q62  = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0] PI_OVER_2_Q62  = 64'h6487_ED51_10B4_611A;
  localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE_60DB_9391_054A;
  localparam logic [63:0] ROUND_Q62      = 64'd1 << 29;

  // classification made on entry
  typedef struct packed {
    logic de_neg;
    logic dn_neg;
    logic ax_zero;
    logic ay_zero;
  } cls_t;

  typedef struct packed {
    cls_t        cls;
    logic [31:0] ax;
    logic [31:0] ay;
  } item_t;

  // one CORDIC / square root stage
  typedef struct packed {
    cls_t        cls;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] z;
    logic [63:0] s;
    logic [63:0] r;
  } iter_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic [1:0] count;
  } qstat_t;

  // long division by shift and subtract, elaboration only
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(2^-i) in radians scaled by 2^62, by its power series
  function automatic logic [63:0] atan_q62(int unsigned i);
    logic [63:0] sum;
    logic [63:0] t;
    int unsigned e;
    sum = '0;
    if (i == 0) begin
      return PI_OVER_4_Q62;
    end
    for (int unsigned k = 0; k < 32; k++) begin
      e = i * (2 * k + 1);
      if (e <= 62) begin
        t = udiv64(64'd1 << (62 - e), 64'(2 * k + 1));
        if (k[0]) begin
          sum = sum - t;
        end else begin
          sum = sum + t;
        end
      end
    end
    return sum;
  endfunction

endpackage

FILE: sv/sjdb_front.sv
// Front end: takes a point pair, forms the differences, magnitudes and classes.
// Depends on sjdb_pkg.
`timescale 1ns / 1ps
module sjdb_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [30:0] start_east_i,
  input  logic signed [30:0] start_north_i,
  input  logic signed [30:0] end_east_i,
  input  logic signed [30:0] end_north_i,
  input  logic               full_i,
  output logic               push_o,
  output sjdb_pkg::item_t    item_o
);
  import sjdb_pkg::*;

  logic        v_q, v_d;
  item_t       item_q, item_d;
  logic signed [31:0] de, dn;
  logic        accept;

  // differences and magnitudes
  always_comb begin
    de = 32'(end_east_i) - 32'(start_east_i);
    dn = 32'(end_north_i) - 32'(start_north_i);
    item_d.cls.de_neg  = de[31];
    item_d.cls.dn_neg  = dn[31];
    item_d.ax          = dn[31] ? 32'(-dn) : 32'(dn);
    item_d.ay          = de[31] ? 32'(-de) : 32'(de);
    item_d.cls.ax_zero = (dn == '0);
    item_d.cls.ay_zero = (de == '0);
  end

  assign in_stall_o = v_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = v_q && !full_i;
  assign item_o     = item_q;

  // hold one beat until the queue takes it
  always_comb begin
    v_d = v_q;
    if (accept) begin
      v_d = 1'b1;
    end else if (push_o) begin
      v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end
endmodule

FILE: sv/sjdb_queue.sv
// Two-entry queue between front and back end.
// Depends on sjdb_pkg.
`timescale 1ns / 1ps
module sjdb_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sjdb_pkg::item_t  item_i,
  input  logic             pop_i,
  output logic             valid_o,
  output sjdb_pkg::item_t  item_o,
  output sjdb_pkg::qstat_t stat_o
);
  import sjdb_pkg::*;

  item_t      mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign valid_o      = (cnt_q != 2'd0);
  assign item_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign stat_o.count = cnt_q;

  // advance pointers and count
  always_comb begin
    wr_d  = push_i ? !wr_q : wr_q;
    rd_d  = pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end
endmodule

FILE: sv/sjdb_back.sv
// Back end: normalise, CORDIC vectoring and square root pipeline, angle scaling.
// Depends on sjdb_pkg.
`timescale 1ns / 1ps
module sjdb_back #(
  parameter int unsigned CORDIC_STAGES = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  sjdb_pkg::item_t item_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [31:0]     distance_o,
  output logic [31:0]     bearing_o
);
  import sjdb_pkg::*;

  localparam int unsigned NSTG = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;

  logic en;

  // stage A: squares and normalising shift
  logic        a_v_q;
  cls_t        a_cls_q;
  logic [31:0] a_ax_q, a_ay_q;
  logic [63:0] a_sqx_q, a_sqy_q;
  logic [5:0]  a_sh_q, a_sh_d;
  logic [31:0] a_m;

  // iteration stages
  iter_t       st_q [NSTG+1];
  logic [NSTG:0] v_q;

  // stage C: clamp and round
  logic        c_v_q;
  cls_t        c_cls_q;
  logic [62:0] c_z_q;
  logic [31:0] c_dist_q;
  logic [63:0] c_z;
  iter_t       last;

  // stage M1 / M2: scale by 1/(2 pi)
  logic        m1_v_q, m2_v_q;
  cls_t        m1_cls_q, m2_cls_q;
  logic [31:0] m1_dist_q, m2_dist_q;
  logic [63:0] m1_ll_q, m1_lh_q, m1_hl_q, m1_hh_q;
  logic [63:0] mid, m2_c_d, m2_c_q;

  // output register
  logic        o_v_q;
  logic [31:0] o_dist_q, o_bear_q, o_bear_d;
  logic [63:0] rnd;
  logic [31:0] qa, ang;

  assign en          = !(o_v_q && out_stall_i);
  assign pop_o       = en && q_valid_i;
  assign out_valid_o = o_v_q;
  assign distance_o  = o_dist_q;
  assign bearing_o   = o_bear_q;

  // find the leading one of the larger magnitude
  always_comb begin
    a_m    = item_i.ax | item_i.ay;
    a_sh_d = 6'd59;
    for (int j = 0; j < 32; j++) begin
      if (a_m[j]) begin
        a_sh_d = 6'(59 - j);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_cls_q <= item_i.cls;
      a_ax_q  <= item_i.ax;
      a_ay_q  <= item_i.ay;
      a_sqx_q <= item_i.ax * item_i.ax;
      a_sqy_q <= item_i.ay * item_i.ay;
      a_sh_q  <= a_sh_d;
    end
  end

  // stage B: shift into place, sum the squares
  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q[0].cls <= a_cls_q;
      st_q[0].x   <= {32'd0, a_ax_q} << a_sh_q;
      st_q[0].y   <= {32'd0, a_ay_q} << a_sh_q;
      st_q[0].z   <= '0;
      st_q[0].s   <= a_sqx_q + a_sqy_q;
      st_q[0].r   <= '0;
    end
  end

  // one CORDIC rotation (stages below CORDIC_STAGES) and one root digit (stages below SQRT_STEPS) per stage
  for (genvar i = 0; i < NSTG; i++) begin : g_stage
    localparam logic [63:0] ATAN = atan_q62(i);
    localparam int unsigned SB   = (i < SQRT_STEPS) ? 62 - 2 * i : 0;
    localparam logic [63:0] BIT  = 64'd1 << SB;
    iter_t cur, nxt;
    logic [63:0] xs, ys, trial;
    always_comb begin
      cur   = st_q[i];
      nxt   = cur;
      xs    = cur.x >> i;
      ys    = 64'($signed(cur.y) >>> i);
      trial = cur.r + BIT;
      if (i < CORDIC_STAGES) begin
        if (!cur.y[63]) begin
          nxt.x = cur.x + ys;
          nxt.y = cur.y - xs;
          nxt.z = cur.z + ATAN;
        end else begin
          nxt.x = cur.x - ys;
          nxt.y = cur.y + xs;
          nxt.z = cur.z - ATAN;
        end
      end
      if (i < SQRT_STEPS) begin
        if (cur.s >= trial) begin
          nxt.s = cur.s - trial;
          nxt.r = (cur.r >> 1) + BIT;
        end else begin
          nxt.r = cur.r >> 1;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        st_q[i+1] <= nxt;
      end
    end
  end

  // clamp the angle to the first quadrant, round the root
  always_comb begin
    last = st_q[NSTG];
    c_z  = last.z;
    if (c_z[63]) begin
      c_z = '0;
    end else if (c_z > PI_OVER_2_Q62) begin
      c_z = PI_OVER_2_Q62;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_cls_q  <= last.cls;
      c_z_q    <= c_z[62:0];
      c_dist_q <= last.r[31:0] + {31'd0, (last.s > last.r)};
    end
  end

  // partial products of the scaling multiply
  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_cls_q  <= c_cls_q;
      m1_dist_q <= c_dist_q;
      m1_ll_q   <= c_z_q[31:0] * INV_TWO_PI_Q64[31:0];
      m1_lh_q   <= c_z_q[31:0] * INV_TWO_PI_Q64[63:32];
      m1_hl_q   <= {1'b0, c_z_q[62:32]} * INV_TWO_PI_Q64[31:0];
      m1_hh_q   <= {1'b0, c_z_q[62:32]} * INV_TWO_PI_Q64[63:32];
    end
  end

  // sum into the high word of the product
  always_comb begin
    mid    = {32'd0, m1_ll_q[63:32]} + {32'd0, m1_lh_q[31:0]} + {32'd0, m1_hl_q[31:0]};
    m2_c_d = m1_hh_q + {32'd0, m1_lh_q[63:32]} + {32'd0, m1_hl_q[63:32]}
           + {32'd0, mid[63:32]};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_cls_q  <= m1_cls_q;
      m2_dist_q <= m1_dist_q;
      m2_c_q    <= m2_c_d;
    end
  end

  // round, pick the special cases, map to the quadrant
  always_comb begin
    rnd = m2_c_q + ROUND_Q62;
    if (m2_cls_q.ay_zero) begin
      qa = '0;
    end else if (m2_cls_q.ax_zero) begin
      qa = QUARTER_TURN;
    end else begin
      qa = rnd[61:30];
    end
    if (!m2_cls_q.dn_neg) begin
      ang = m2_cls_q.de_neg ? 32'd0 - qa : qa;
    end else begin
      ang = m2_cls_q.de_neg ? qa - HALF_TURN : HALF_TURN - qa;
    end
    o_bear_d = ang + HALF_TURN;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_dist_q <= m2_dist_q;
      o_bear_q <= o_bear_d;
    end
  end

  // valid bits advance with the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q  <= 1'b0;
      v_q    <= '0;
      c_v_q  <= 1'b0;
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else if (en) begin
      a_v_q  <= q_valid_i;
      v_q    <= {v_q[NSTG-1:0], a_v_q};
      c_v_q  <= v_q[NSTG];
      m1_v_q <= c_v_q;
      m2_v_q <= m1_v_q;
      o_v_q  <= m2_v_q;
    end
  end
endmodule

FILE: sv/survey_join_distance_bearing.sv
// Channel  | valid        | stall        | payload
// ---------+--------------+--------------+--------------------------------------------
// input    | in_valid_i   | in_stall_o   | start_east_i start_north_i end_east_i end_north_i
// output   | out_valid_o  | out_stall_i  | distance_o bearing_o
//
// One point pair accepted per cycle while in_stall_o is low; out_valid_o rises once
// the pair has passed the front register, the queue and the unrolled CORDIC / root
// pipeline in the back end.
// Reset clears valid bits and the queue only; no clearing pass is needed.
// An output stall freezes the back pipeline; the two-entry queue and the front
// register absorb up to three further beats before in_stall_o rises.
// Top level of the survey join block; depends on sjdb_pkg, sjdb_front,
// sjdb_queue, sjdb_back and the assertion macro header.
`timescale 1ns / 1ps
`include "survey_join_distance_bearing_defines.svh"
module survey_join_distance_bearing #(
  parameter int unsigned CORDIC_STAGES = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [30:0] start_east_i,
  input  logic signed [30:0] start_north_i,
  input  logic signed [30:0] end_east_i,
  input  logic signed [30:0] end_north_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        distance_o,
  output logic [31:0]        bearing_o
);
  import sjdb_pkg::*;

  logic   push, pop, q_valid;
  item_t  f_item, q_item;
  qstat_t qstat;

  sjdb_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .start_east_i,
    .start_north_i,
    .end_east_i,
    .end_north_i,
    .full_i (qstat.full),
    .push_o (push),
    .item_o (f_item)
  );

  sjdb_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .item_i  (f_item),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item),
    .stat_o  (qstat)
  );

  sjdb_back #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i (q_valid),
    .item_i    (q_item),
    .pop_o     (pop),
    .out_valid_o,
    .out_stall_i,
    .distance_o,
    .bearing_o
  );

  // queue bookkeeping checks
  `SJDB_ASSERT(a_pop_has_item, pop |-> q_valid, "pop from empty queue")
  `SJDB_ASSERT(a_push_lands, push && !pop |=> !qstat.empty, "pushed beat lost")
  `SJDB_ASSERT(a_count_bound, qstat.count <= 2'd2, "queue count overflow")
endmodule
